// ===== rtl/core/fc_pkg.sv =====
package fc_pkg;

   localparam int PLANE_REGS = 6;
   localparam int PLANE_IDX_W = 3;
   localparam int PLANE_W = 64;
   localparam int COORD_W = 17;
   localparam int PROD_W = 33;
   localparam int SUM_W = 35;
   localparam int CORNERS = 8;
   localparam int DIST_OUT_W = 19;

   typedef enum logic [2:0] {
      MODE_CUBE   = 3'd0,
      MODE_BOX    = 3'd1,
      MODE_POINT  = 3'd2,
      MODE_PLANE  = 3'd3,
      MODE_SPHERE = 3'd4
   } mode_type;

   localparam logic [1:0] CLS_INSIDE    = 2'd0;
   localparam logic [1:0] CLS_INTERSECT = 2'd1;
   localparam logic [1:0] CLS_OUTSIDE   = 2'd2;

   typedef logic signed [COORD_W-1:0] coord_type;

   // Control fields that ride along with each transaction.
   typedef struct packed {
      logic                   valid;
      logic [2:0]             mode;
      logic [PLANE_IDX_W-1:0] pidx;
      coord_type              neg_radius;
   } ctl_type;

endpackage

// ===== rtl/core/fc_req_if.sv =====
interface fc_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         mode;
   logic [2:0]         plane_index;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic signed [15:0] pos_z;
   logic signed [15:0] ext_x;
   logic signed [15:0] ext_y;
   logic signed [15:0] ext_z;

   modport source (output valid, mode, plane_index, pos_x, pos_y, pos_z,
                   ext_x, ext_y, ext_z, input ready);
   modport sink (input valid, mode, plane_index, pos_x, pos_y, pos_z,
                 ext_x, ext_y, ext_z, output ready);
endinterface

// ===== rtl/core/fc_rsp_if.sv =====
interface fc_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         classification;
   logic               visible;
   logic signed [18:0] plane_distance;

   modport source (output valid, classification, visible, plane_distance,
                   input ready);
   modport sink (input valid, classification, visible, plane_distance,
                 output ready);
endinterface

// ===== rtl/core/fc_plane.sv =====
module fc_plane
   import fc_pkg::*;
#(
   parameter int FRAC_BITS = 14,
   parameter int DIST_W = SUM_W - FRAC_BITS + 1
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [PLANE_W-1:0]       coef,
   input  coord_type                xs [2],
   input  coord_type                ys [2],
   input  coord_type                zs [2],
   output logic signed [DIST_W-1:0] corner_dist [CORNERS]
);

   logic signed [PROD_W-1:0] ax_ff [2];
   logic signed [PROD_W-1:0] by_ff [2];
   logic signed [PROD_W-1:0] cz_ff [2];
   logic signed [15:0]       d_ff;
   logic signed [DIST_W-1:0] dist_ff [CORNERS];
   logic signed [DIST_W-1:0] dist_in [CORNERS];

   logic signed [15:0] ca, cb, cc;
   assign ca = coef[15:0];
   assign cb = coef[31:16];
   assign cc = coef[47:32];

   // Products: two coordinate values per axis.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 2; i++) begin
            ax_ff[i] <= ca * xs[i];
            by_ff[i] <= cb * ys[i];
            cz_ff[i] <= cc * zs[i];
         end
         d_ff <= coef[63:48];
      end
   end

   always_comb begin
      logic signed [SUM_W-1:0] sum;
      for (int k = 0; k < CORNERS; k++) begin
         sum = SUM_W'(ax_ff[k & 1]) + SUM_W'(by_ff[(k >> 1) & 1])
               + SUM_W'(cz_ff[(k >> 2) & 1]);
         dist_in[k] = $signed({sum[SUM_W-1], sum[SUM_W-1:FRAC_BITS]})
                      + DIST_W'(d_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff <= dist_in;
      end
   end

   assign corner_dist = dist_ff;

endmodule

// ===== rtl/core/frustum_cull_test.sv =====
// Six-plane frustum culling test.
// req_chan carries one volume per transaction (mode, plane_index, position
// and extent fields); rsp_chan returns classification, visible and
// plane_distance for it, in order. Planes are written on csr_* one per
// register index (near, far, left, right, bottom, top); the user must
// write them only while the block idles; the block does not enforce it.
// Four register stages; one transaction is accepted every cycle unless
// the receiver stalls. The path is: corner coordinates, coefficient
// products, corner distances, plane reduction into the response register.
// Each plane has its own multipliers, so the rate does not depend on mode.
// When the receiver stalls, the whole pipeline holds and req_chan.ready
// drops; nothing is lost or repeated. Reset clears the pipeline valid bits
// and all plane registers to zero.
module frustum_cull_test
   import fc_pkg::*;
#(
   parameter int NUM_PLANES = 6,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                   clock,
   input  logic                   reset,
   fc_req_if.sink                 req_chan,
   fc_rsp_if.source               rsp_chan,
   input  logic                   csr_we,
   input  logic [PLANE_IDX_W-1:0] csr_index,
   input  logic [PLANE_W-1:0]     csr_data
);

   localparam int DIST_W = SUM_W - NORMAL_FRAC_BITS + 1;

   logic [PLANE_W-1:0] plane_ff [PLANE_REGS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PLANE_REGS; i++) plane_ff[i] <= '0;
      end else if (csr_we && (int'(csr_index) < PLANE_REGS)) begin
         plane_ff[csr_index] <= csr_data;
      end
   end

   logic adv;
   logic rsp_valid_ff;
   assign adv = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // Stage 1: corner coordinates.
   ctl_type   s1_ff, s2_ff, s3_ff, s1_in;
   coord_type xs_ff [2], ys_ff [2], zs_ff [2];
   coord_type xs_in [2], ys_in [2], zs_in [2];

   always_comb begin
      coord_type px, py, pz, ex, ey, ez;
      px = COORD_W'(req_chan.pos_x);
      py = COORD_W'(req_chan.pos_y);
      pz = COORD_W'(req_chan.pos_z);
      ex = COORD_W'(req_chan.ext_x);
      ey = COORD_W'(req_chan.ext_y);
      ez = COORD_W'(req_chan.ext_z);
      priority if (req_chan.mode == MODE_CUBE) begin
         xs_in[0] = px - ex; xs_in[1] = px + ex;
         ys_in[0] = py - ey; ys_in[1] = py + ey;
         zs_in[0] = pz - ez; zs_in[1] = pz + ez;
      end else if (req_chan.mode == MODE_BOX) begin
         xs_in[0] = px; xs_in[1] = ex;
         ys_in[0] = py; ys_in[1] = ey;
         zs_in[0] = pz; zs_in[1] = ez;
      end else begin
         xs_in[0] = px; xs_in[1] = px;
         ys_in[0] = py; ys_in[1] = py;
         zs_in[0] = pz; zs_in[1] = pz;
      end
      s1_in.valid = req_chan.valid;
      s1_in.mode = req_chan.mode;
      s1_in.pidx = req_chan.plane_index;
      s1_in.neg_radius = -ex;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
      end else if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
         xs_ff <= xs_in;
         ys_ff <= ys_in;
         zs_ff <= zs_in;
      end
   end

   // Stages 2 and 3: per-plane products and corner distances.
   logic signed [DIST_W-1:0] corner_dist [NUM_PLANES][CORNERS];

   for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
      logic [PLANE_W-1:0] coef;
      if (p < PLANE_REGS) begin : g_reg
         assign coef = plane_ff[p];
      end else begin : g_zero
         assign coef = '0;
      end
      fc_plane #(.FRAC_BITS(NORMAL_FRAC_BITS), .DIST_W(DIST_W)) u_plane (
         .clock       (clock),
         .en          (adv),
         .coef        (coef),
         .xs          (xs_ff),
         .ys          (ys_ff),
         .zs          (zs_ff),
         .corner_dist (corner_dist[p])
      );
   end

   // Stage 4: reduce over planes and corners.
   logic [1:0]                cls_in, cls_ff;
   logic                      vis_in, vis_ff;
   logic signed [DIST_OUT_W-1:0] pd_in, pd_ff;

   always_comb begin
      logic any_all_below, any_below, any_no_above, pt_fail, sph_fail, hit;
      logic signed [DIST_W-1:0] sel, negr;
      logic [CORNERS-1:0] below, above;
      any_all_below = 1'b0;
      any_below = 1'b0;
      any_no_above = 1'b0;
      pt_fail = 1'b0;
      sph_fail = 1'b0;
      hit = 1'b0;
      sel = '0;
      negr = DIST_W'(s3_ff.neg_radius);
      for (int p = 0; p < NUM_PLANES; p++) begin
         for (int k = 0; k < CORNERS; k++) begin
            below[k] = corner_dist[p][k] < 0;
            above[k] = corner_dist[p][k] > 0;
         end
         any_all_below |= &below;
         any_below |= |below;
         any_no_above |= ~|above;
         pt_fail |= corner_dist[p][0] <= 0;
         sph_fail |= corner_dist[p][0] <= negr;
         if (int'(s3_ff.pidx) == p) begin
            hit = 1'b1;
            sel = corner_dist[p][0];
         end
      end
      cls_in = CLS_INSIDE;
      vis_in = 1'b0;
      pd_in = '0;
      case (s3_ff.mode)
         MODE_CUBE: begin
            cls_in = any_all_below ? CLS_OUTSIDE
                   : (any_below ? CLS_INTERSECT : CLS_INSIDE);
            vis_in = !any_all_below;
         end
         MODE_BOX:    vis_in = !any_no_above;
         MODE_POINT:  vis_in = !pt_fail;
         MODE_PLANE: begin
            if (hit) begin
               pd_in = sel[DIST_OUT_W-1:0];
               vis_in = sel > 0;
            end
         end
         MODE_SPHERE: vis_in = !sph_fail;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s3_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cls_ff <= cls_in;
         vis_ff <= vis_in;
         pd_ff <= pd_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.classification = cls_ff;
   assign rsp_chan.visible = vis_ff;
   assign rsp_chan.plane_distance = pd_ff;

   a_outside_hidden: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && cls_ff == CLS_OUTSIDE |-> !vis_ff)
      else $error("outside volume reported visible");

   a_neg_dist_hidden: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && pd_ff[DIST_OUT_W-1] |-> !vis_ff)
      else $error("negative distance reported visible");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      s3_ff.valid && adv |=> rsp_valid_ff)
      else $error("stage three transaction dropped");

endmodule

// ===== tb/frustum_cull_checker.sv =====
`timescale 1ns / 1ps

module frustum_cull_checker
   import fc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   fc_req_if                      req,
   fc_rsp_if                      rsp,
   input  logic                   csr_we,
   input  logic [PLANE_IDX_W-1:0] csr_index,
   input  logic [PLANE_W-1:0]     csr_data,
   output int                     fail_count,
   output int                     pending
);

   localparam int NUM_PLANES = 6;
   localparam int FRAC_BITS = 14;

   typedef struct packed {
      logic [1:0]         classification;
      logic               visible;
      logic signed [18:0] plane_distance;
   } cull_result_type;

   logic [PLANE_W-1:0] planes [PLANE_REGS];
   cull_result_type    expected_results[$];

   function automatic longint coef(input logic [PLANE_W-1:0] w, input int sel);
      logic signed [15:0] f;
      f = w[sel*16 +: 16];
      return longint'(f);
   endfunction

   function automatic longint plane_distance(input int p, input longint x,
                                             input longint y, input longint z);
      longint acc;
      if (p >= PLANE_REGS) return 0;
      acc = coef(planes[p], 0) * x + coef(planes[p], 1) * y + coef(planes[p], 2) * z;
      return (acc >>> FRAC_BITS) + coef(planes[p], 3);
   endfunction

   function automatic cull_result_type classify_volume(
      input logic [2:0] mode, input logic [2:0] pidx,
      input logic signed [15:0] px, input logic signed [15:0] py,
      input logic signed [15:0] pz, input logic signed [15:0] ex,
      input logic signed [15:0] ey, input logic signed [15:0] ez);
      cull_result_type r;
      longint xs[2], ys[2], zs[2];
      longint d;
      int below, above;
      bit done;
      r = '0;
      done = 0;
      case (mode)
         MODE_CUBE, MODE_BOX: begin
            if (mode == MODE_CUBE) begin
               xs[0] = px - ex; xs[1] = px + ex;
               ys[0] = py - ey; ys[1] = py + ey;
               zs[0] = pz - ez; zs[1] = pz + ez;
            end else begin
               xs[0] = px; xs[1] = ex;
               ys[0] = py; ys[1] = ey;
               zs[0] = pz; zs[1] = ez;
            end
            r.visible = 1;
            for (int p = 0; p < NUM_PLANES && !done; p++) begin
               below = 0;
               above = 0;
               for (int k = 0; k < 8; k++) begin
                  d = plane_distance(p, xs[k & 1], ys[(k >> 1) & 1], zs[(k >> 2) & 1]);
                  if (d < 0) below++;
                  if (d > 0) above++;
               end
               if (mode == MODE_CUBE) begin
                  if (below == 8) begin
                     r.classification = CLS_OUTSIDE;
                     done = 1;
                  end else if (below != 0) r.classification = CLS_INTERSECT;
               end else if (above == 0) begin
                  r.visible = 0;
                  done = 1;
               end
            end
            if (mode == MODE_CUBE) r.visible = (r.classification != CLS_OUTSIDE);
         end
         MODE_POINT: begin
            r.visible = 1;
            for (int p = 0; p < NUM_PLANES; p++)
               if (plane_distance(p, px, py, pz) <= 0) r.visible = 0;
         end
         MODE_PLANE: begin
            if (pidx < NUM_PLANES) begin
               d = plane_distance(pidx, px, py, pz);
               r.plane_distance = d[18:0];
               r.visible = d > 0;
            end
         end
         MODE_SPHERE: begin
            r.visible = 1;
            for (int p = 0; p < NUM_PLANES; p++)
               if (plane_distance(p, px, py, pz) <= -longint'(ex)) r.visible = 0;
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   assign pending = expected_results.size();

   always @(posedge clock) begin
      cull_result_type got, want;
      if (reset) begin
         for (int i = 0; i < PLANE_REGS; i++) planes[i] <= '0;
         fail_count <= 0;
      end else begin
         if (req.valid && req.ready)
            expected_results.push_back(classify_volume(req.mode, req.plane_index,
               req.pos_x, req.pos_y, req.pos_z, req.ext_x, req.ext_y, req.ext_z));
         if (rsp.valid && rsp.ready) begin
            got = {rsp.classification, rsp.visible, rsp.plane_distance};
            if (expected_results.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected transaction: cls=%0d vis=%0d dist=%0d",
                           got.classification, got.visible, got.plane_distance);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("mismatch: expected cls=%0d vis=%0d dist=%0d, got cls=%0d vis=%0d dist=%0d",
                              want.classification, want.visible, want.plane_distance,
                              got.classification, got.visible, got.plane_distance);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (csr_we && csr_index < PLANE_REGS) planes[csr_index] <= csr_data;
      end
   end

endmodule

// ===== tb/frustum_cull_test_test.sv =====
`timescale 1ns / 1ps

module frustum_cull_test_test;
   import fc_pkg::*;

   logic                   clock = 0;
   logic                   reset = 1;
   logic                   csr_we = 0;
   logic [PLANE_IDX_W-1:0] csr_index = '0;
   logic [PLANE_W-1:0]     csr_data = '0;
   int                     fail_count;
   int                     pending;
   int                     burst_left = 0;
   int                     stall_cycle = 0;

   fc_req_if req_chan();
   fc_rsp_if rsp_chan();

   frustum_cull_test u_top (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   frustum_cull_checker u_checker (
      .clock(clock), .reset(reset), .req(req_chan), .rsp(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   always #1 clock = ~clock;

   initial begin
      req_chan.valid = 0;
      req_chan.mode = '0;
      req_chan.plane_index = '0;
      req_chan.pos_x = '0;
      req_chan.pos_y = '0;
      req_chan.pos_z = '0;
      req_chan.ext_x = '0;
      req_chan.ext_y = '0;
      req_chan.ext_z = '0;
      rsp_chan.ready = 0;
   end

   // receiver: open stretches, light stalls and heavy stalls in turn
   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 1;
      if (stall_cycle % 300 < 80) rsp_chan.ready <= 1;
      else if (stall_cycle % 300 < 200) rsp_chan.ready <= ($urandom_range(0, 3) != 0);
      else rsp_chan.ready <= ($urandom_range(0, 2) == 0);
   end

   function automatic logic [63:0] pack_plane(input logic [15:0] a, input logic [15:0] b,
                                              input logic [15:0] c, input logic [15:0] d);
      return {d, c, b, a};
   endfunction

   function automatic logic signed [15:0] rand_coord();
      case ($urandom_range(0, 4))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 511) - 256);
         2: case ($urandom_range(0, 3))
               0: return 16'sh7fff;
               1: return 16'sh8000;
               2: return 16'sh0000;
               default: return 16'shffff;
            endcase
         default: return 16'($urandom_range(0, 4095) - 2048);
      endcase
   endfunction

   function automatic logic signed [15:0] rand_extent();
      if ($urandom_range(0, 3) != 0) return 16'($urandom_range(0, 1023));
      return rand_coord();
   endfunction

   task automatic write_planes(input logic [63:0] p [PLANE_REGS]);
      for (int i = 0; i < PLANE_REGS; i++) begin
         csr_we <= 1;
         csr_index <= PLANE_IDX_W'(i);
         csr_data <= p[i];
         @(posedge clock);
      end
      csr_we <= 0;
   endtask

   task automatic drain();
      req_chan.valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic send_volume(input logic [2:0] mode, input logic [2:0] pidx,
                              input logic signed [15:0] px, input logic signed [15:0] py,
                              input logic signed [15:0] pz, input logic signed [15:0] ex,
                              input logic signed [15:0] ey, input logic signed [15:0] ez);
      if (burst_left == 0) begin
         req_chan.valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_chan.valid <= 1;
      req_chan.mode <= mode;
      req_chan.plane_index <= pidx;
      req_chan.pos_x <= px;
      req_chan.pos_y <= py;
      req_chan.pos_z <= pz;
      req_chan.ext_x <= ex;
      req_chan.ext_y <= ey;
      req_chan.ext_z <= ez;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      logic [2:0]         mode;
      logic signed [15:0] px, py, pz, ex, ey, ez;
      for (int n = 0; n < count; n++) begin
         mode = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
         px = rand_coord();
         py = rand_coord();
         pz = rand_coord();
         ex = rand_extent();
         ey = rand_extent();
         ez = rand_extent();
         // mostly well-ordered boxes
         if (mode == MODE_BOX && $urandom_range(0, 3) != 0) begin
            ex = (px > 16'sh7000) ? px : px + ex[11:0];
            ey = (py > 16'sh7000) ? py : py + ey[11:0];
            ez = (pz > 16'sh7000) ? pz : pz + ez[11:0];
         end
         send_volume(mode, 3'($urandom_range(0, 7)), px, py, pz, ex, ey, ez);
         if (n == count / 2 && $urandom_range(0, 1)) drain();
      end
   endtask

   initial begin
      logic [63:0] planes [PLANE_REGS];
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // all planes zero after reset
      send_volume(MODE_CUBE, 0, 100, 200, 300, 10, 10, 10);
      send_volume(MODE_POINT, 0, 1, 1, 1, 0, 0, 0);
      send_volume(MODE_PLANE, 2, 16'sh7fff, 16'sh8000, 5, 0, 0, 0);
      send_volume(MODE_SPHERE, 0, 0, 0, 0, -16, 0, 0);
      drain();

      // a unit-cube frustum
      planes[0] = pack_plane(16'h0000, 16'h0000, 16'h4000, 16'h0400);
      planes[1] = pack_plane(16'h0000, 16'h0000, 16'hc000, 16'h0400);
      planes[2] = pack_plane(16'h4000, 16'h0000, 16'h0000, 16'h0400);
      planes[3] = pack_plane(16'hc000, 16'h0000, 16'h0000, 16'h0400);
      planes[4] = pack_plane(16'h0000, 16'h4000, 16'h0000, 16'h0400);
      planes[5] = pack_plane(16'h0000, 16'hc000, 16'h0000, 16'h0400);
      write_planes(planes);
      send_volume(MODE_CUBE, 0, 0, 0, 0, 16, 16, 16);
      send_volume(MODE_CUBE, 0, 1000, 0, 0, 100, 100, 100);
      send_volume(MODE_CUBE, 0, 5000, 0, 0, 16, 16, 16);
      send_volume(MODE_CUBE, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_volume(MODE_CUBE, 0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      send_volume(MODE_CUBE, 0, 0, 0, 0, -100, -100, -100);
      send_volume(MODE_BOX, 0, -100, -100, -100, 100, 100, 100);
      send_volume(MODE_BOX, 0, 100, 100, 100, -100, -100, -100);
      send_volume(MODE_BOX, 0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_volume(MODE_POINT, 0, 0, 0, 0, 0, 0, 0);
      send_volume(MODE_POINT, 0, 1024, 0, 0, 0, 0, 0);
      send_volume(MODE_PLANE, 0, 0, 0, 16'sh7fff, 0, 0, 0);
      send_volume(MODE_PLANE, 5, 0, 16'sh8000, 0, 0, 0, 0);
      send_volume(MODE_PLANE, 6, 1, 2, 3, 0, 0, 0);
      send_volume(MODE_PLANE, 7, 1, 2, 3, 0, 0, 0);
      send_volume(MODE_SPHERE, 0, 1100, 0, 0, 100, 0, 0);
      send_volume(MODE_SPHERE, 0, 0, 0, 0, -2000, 0, 0);
      send_volume(MODE_SPHERE, 0, 16'sh8000, 0, 0, 16'sh7fff, 0, 0);
      send_volume(3'd5, 3, 1, 2, 3, 4, 5, 6);
      send_volume(3'd7, 7, -1, -1, -1, -1, -1, -1);
      send_random(300);
      drain();

      // extreme coefficients
      for (int i = 0; i < PLANE_REGS; i++)
         planes[i] = (i % 2) ? 64'h8000_8000_8000_8000 : 64'h7fff_7fff_7fff_7fff;
      write_planes(planes);
      send_random(150);
      drain();

      for (int i = 0; i < PLANE_REGS; i++) planes[i] = '1;
      write_planes(planes);
      send_random(100);
      drain();

      for (int r = 0; r < 2; r++) begin
         for (int i = 0; i < PLANE_REGS; i++) planes[i] = {$urandom, $urandom};
         write_planes(planes);
         send_random(240);
         drain();
      end

      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   initial begin
      #1000000;
      $display("FAILURE");
      $finish;
   end

endmodule
